/* rtl/arxsk_pkg.sv */
// Shared types, constants and round functions of the ARX sponge keystream cipher.
`timescale 1ns / 1ps
`default_nettype none
package arxsk_pkg;

   // Rounds per block and round counter width
   localparam int ROUNDS = 25;
   localparam int RND_W  = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

   // Register file geometry: six 64-bit registers at 8-byte spacing
   localparam int NUM_REGS   = 6;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_ADDR_W = CSR_IDX_W + 3;

   localparam logic [CSR_IDX_W-1:0] REG_KEY_0   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_1   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_2   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_3   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_NONCE_0 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_NONCE_1 = 3'd5;

   // Block of four 64-bit words
   localparam int WORD_W  = 64;
   localparam int BLOCK_W = 4 * WORD_W;

   localparam int NUM_LANES = 25;

   typedef logic [31:0] lanes_type [NUM_LANES];
   typedef logic [NUM_REGS-1:0][CSR_DATA_W-1:0] cfg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } ctrl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;   // take the input transfer, reload lanes if needed
      logic round;     // apply one round to the lanes
      logic emit;      // load the result register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_free;  // result register empty or being drained
   } sts_type;

   localparam lanes_type LANE_INIT = '{
      32'h923c44fc, 32'hf867f0f6, 32'hc2e5cc28, 32'h8ecebfd4, 32'hcb632744,
      32'h90a142fa, 32'hea942e3a, 32'h9c70db80, 32'hba55d7e1, 32'he3b1f8a2,
      32'hc60865e0, 32'hf8112cc2, 32'h93d6b989, 32'hc1cf8477, 32'h812b7f3c,
      32'h8c776893, 32'hcea9b7e1, 32'hdb51dd82, 32'hcf9e6886, 32'hc2a7551c,
      32'ha9e3e82b, 32'he77979d1, 32'head7c4bb, 32'heda04895, 32'hbe61724c
   };

   // Rotate left by a constant amount of 1..31
   function automatic logic [31:0] rol32(input logic [31:0] a, input int unsigned n);
      return (a << n) | (a >> (32 - n));
   endfunction

   // Lane r,c sits at index 5*r+c
   function automatic lanes_type arxsk_round(input lanes_type a);
      lanes_type s;
      lanes_type r;
      s = a;
      // pass A
      s[0]  = s[0]  + s[8]  + s[17];
      s[6]  = s[6]  + s[14] + s[23];
      s[12] = s[12] + s[15] + s[4];
      s[18] = s[18] + s[21] + s[5];
      s[24] = s[24] + s[2]  + s[10];
      // pass B
      s[17] = s[17] ^ (~rol32(s[22], 2) & rol32(s[0], 3));
      s[23] = s[23] ^ (~s[6] & rol32(s[3], 6));
      s[4]  = s[4]  ^ (~rol32(s[9], 4) & s[12]);
      s[5]  = s[5]  ^ (~rol32(s[18], 11) & rol32(s[10], 8));
      s[11] = s[11] ^ (~s[16] & s[24]);
      // pass C
      s[22] = s[22] + s[17] + s[13];
      s[3]  = s[3]  + s[23] + s[19];
      s[9]  = s[9]  + s[4]  + s[20];
      s[10] = s[10] + s[5]  + s[1];
      s[16] = s[16] + s[11] + s[7];
      // pass D
      s[13] = s[13] ^ (~rol32(s[22], 10) & rol32(s[8], 21));
      s[19] = s[19] ^ (~rol32(s[3], 14) & s[14]);
      s[20] = s[20] ^ (~rol32(s[9], 28) & rol32(s[15], 31));
      s[1]  = s[1]  ^ (~rol32(s[10], 20) & rol32(s[21], 9));
      s[7]  = s[7]  ^ (~rol32(s[16], 23) & s[2]);
      // pass E
      s[8]  = s[8]  + s[13] + s[0];
      s[14] = s[14] + s[19] + s[6];
      s[15] = s[15] + s[20] + s[12];
      s[21] = s[21] + s[1]  + s[18];
      s[2]  = s[2]  + s[7]  + s[24];
      // rows move up, old row 0 wraps to row 4 shifted by one lane
      for (int i = 0; i < 20; i++) begin
         r[i] = s[i + 5];
      end
      r[20] = s[4];
      for (int i = 1; i < 5; i++) begin
         r[20 + i] = s[i - 1];
      end
      return r;
   endfunction

   // Fresh lanes from constants, key and nonce
   function automatic lanes_type arxsk_reload(input cfg_type cfg);
      lanes_type s;
      s = LANE_INIT;
      s[0]  = s[0]  ^ cfg[REG_KEY_0][63:32];
      s[5]  = s[5]  ^ cfg[REG_KEY_0][31:0];
      s[10] = s[10] ^ cfg[REG_KEY_1][63:32];
      s[15] = s[15] ^ cfg[REG_KEY_1][31:0];
      s[20] = s[20] ^ cfg[REG_KEY_2][63:32];
      s[1]  = s[1]  ^ cfg[REG_KEY_2][31:0];
      s[6]  = s[6]  ^ cfg[REG_KEY_3][63:32];
      s[11] = s[11] ^ cfg[REG_KEY_3][31:0];
      s[16] = s[16] ^ cfg[REG_NONCE_0][63:32];
      s[21] = s[21] ^ cfg[REG_NONCE_0][31:0];
      s[2]  = s[2]  ^ cfg[REG_NONCE_1][63:32];
      s[7]  = s[7]  ^ cfg[REG_NONCE_1][31:0];
      return s;
   endfunction

endpackage
`default_nettype wire

/* rtl/arx_sponge_keystream_cipher.sv */
// Top level of the ARX sponge keystream cipher.
//
//  channel | group   | direction | contents
//  --------+---------+-----------+---------------------------------------------
//  req     | stream  | in        | tuser: first_block; tdata: data words 0..3
//  rsp     | stream  | out       | tdata: out words 0..3
//  csr     | APB     | in        | key words at 0x00..0x18, nonce at 0x20..0x28
//
// A block is accepted, then worked one round per cycle in the shared round
// unit, then loaded into the result register.
// Reset is synchronous; it clears the registers, the sequencer and the
// stream-started flag, so the first block always reloads the lanes.
// A result waiting on rsp_tready does not stop the next block being
// accepted and worked; only its own result load waits for the register.
`timescale 1ns / 1ps
`default_nettype none
module arx_sponge_keystream_cipher (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // input stream
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [arxsk_pkg::BLOCK_W-1:0]    req_tdata,  // data_word_0..3, 64b each
   input  wire logic                             req_tuser,  // first_block
   // result stream
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic      [arxsk_pkg::BLOCK_W-1:0]    rsp_tdata,  // out_word_0..3, 64b each
   // configuration
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [arxsk_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [arxsk_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [arxsk_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                  csr_pready
);
   import arxsk_pkg::*;

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;

   arxsk_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   arxsk_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   arxsk_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .cfg        (cfg),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .sts        (sts)
   );

endmodule
`default_nettype wire

/* rtl/arxsk_csr.sv */
// APB-style register file holding the key and nonce words.
`timescale 1ns / 1ps
`default_nettype none
module arxsk_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [arxsk_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [arxsk_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [arxsk_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                  csr_pready,
   output arxsk_pkg::cfg_type                    cfg
);
   import arxsk_pkg::*;

   cfg_type              cfg_ff;
   cfg_type              cfg_in;
   logic [CSR_IDX_W-1:0] idx;
   logic                 idx_ok;
   logic                 wr_en;

   assign idx    = csr_paddr[CSR_ADDR_W-1:3];
   assign idx_ok = (idx < CSR_IDX_W'(NUM_REGS));
   assign wr_en  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   assign csr_pready = 1'b1;

   // write decode; out-of-range indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en && idx_ok) begin
         cfg_in[idx] = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back
   assign csr_prdata = idx_ok ? cfg_ff[idx] : '0;
   assign cfg        = cfg_ff;

endmodule
`default_nettype wire

/* rtl/arxsk_ctrl.sv */
// Sequencer: accepts a block, counts the rounds and hands off the result.
`timescale 1ns / 1ps
`default_nettype none
module arxsk_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire arxsk_pkg::sts_type sts,
   output arxsk_pkg::cmd_type     cmd
);
   import arxsk_pkg::*;

   ctrl_state_type   state_ff;
   ctrl_state_type   state_in;
   logic [RND_W-1:0] cnt_ff;
   logic [RND_W-1:0] cnt_in;
   logic             last_round;

   assign last_round = (cnt_ff == RND_W'(ROUNDS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (last_round) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready  = 1'b0;
      cmd.capture = 1'b0;
      cmd.round   = 1'b0;
      cmd.emit    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_RUN: begin
            cmd.round = 1'b1;
         end
         ST_DONE: begin
            cmd.emit = sts.out_free;
         end
         default: ;
      endcase
   end

   // round counter
   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.capture) begin
         cnt_in = '0;
      end else if (cmd.round && !last_round) begin
         cnt_in = cnt_ff + RND_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/arxsk_datapath.sv */
// Lane state, round logic, keystream mixing and the result register.
`timescale 1ns / 1ps
`default_nettype none
module arxsk_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire arxsk_pkg::cmd_type            cmd,
   input  wire arxsk_pkg::cfg_type            cfg,
   input  wire logic                          req_tuser,
   input  wire logic [arxsk_pkg::BLOCK_W-1:0] req_tdata,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic      [arxsk_pkg::BLOCK_W-1:0] rsp_tdata,
   output arxsk_pkg::sts_type                 sts
);
   import arxsk_pkg::*;

   lanes_type          lanes_ff;
   lanes_type          lanes_in;
   logic               started_ff;
   logic               started_in;
   logic [BLOCK_W-1:0] data_ff;
   logic [BLOCK_W-1:0] out_ff;
   logic               out_valid_ff;
   logic               out_valid_in;
   logic [31:0]        ks [8];
   logic [BLOCK_W-1:0] mixed;

   // lane update: reload on a first block or before any stream, else rounds
   always_comb begin
      lanes_in   = lanes_ff;
      started_in = started_ff;
      if (cmd.capture) begin
         if (req_tuser || !started_ff) begin
            lanes_in   = arxsk_reload(cfg);
            started_in = 1'b1;
         end
      end else if (cmd.round) begin
         lanes_in = arxsk_round(lanes_ff);
      end
   end

   always_ff @(posedge clock) begin
      lanes_ff <= lanes_in;
      if (cmd.capture) begin
         data_ff <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
      end else begin
         started_ff <= started_in;
      end
   end

   // keystream words, three lanes each
   assign ks[0] = lanes_ff[0]  ^ lanes_ff[14] ^ lanes_ff[20];
   assign ks[1] = lanes_ff[6]  ^ lanes_ff[15] ^ lanes_ff[4];
   assign ks[2] = lanes_ff[12] ^ lanes_ff[21] ^ lanes_ff[5];
   assign ks[3] = lanes_ff[18] ^ lanes_ff[2]  ^ lanes_ff[11];
   assign ks[4] = lanes_ff[24] ^ lanes_ff[8]  ^ lanes_ff[17];
   assign ks[5] = lanes_ff[1]  ^ lanes_ff[19] ^ lanes_ff[23];
   assign ks[6] = lanes_ff[7]  ^ lanes_ff[3]  ^ lanes_ff[10];
   assign ks[7] = lanes_ff[13] ^ lanes_ff[9]  ^ lanes_ff[16];

   // big-endian pairs XORed into the data words
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         mixed[i*WORD_W +: WORD_W] = data_ff[i*WORD_W +: WORD_W] ^ {ks[2*i], ks[2*i+1]};
      end
   end

   // result register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_ff <= mixed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = out_ff;
   assign sts.out_free = !out_valid_ff || rsp_tready;

endmodule
`default_nettype wire

/* rtl/arxsk_checker.sv */
// Port-level checks for the cipher top level, bound in below.
`timescale 1ns / 1ps
`default_nettype none
module arxsk_assertions (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_tvalid,
   input wire logic                          req_tready,
   input wire logic                          rsp_tvalid,
   input wire logic                          rsp_tready,
   input wire logic [arxsk_pkg::BLOCK_W-1:0] rsp_tdata
);
   // a stalled result holds its data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // the result register comes out of reset empty
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // an accepted block closes the input straight after the transfer
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input open straight after a transfer");

   // no result can appear in the cycle after a block is taken in
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("result appeared too early");

endmodule

bind arx_sponge_keystream_cipher arxsk_assertions u_arxsk_assertions (.*);
`default_nettype wire
